// File: rtl/core/vlan_query_frame_validator_assert.svh
// Assertion macros for the VLAN query frame validator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef VLAN_QUERY_FRAME_VALIDATOR_ASSERT_SVH
`define VLAN_QUERY_FRAME_VALIDATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define VQFV_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// cons must hold in the cycle after ante
`define VQFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VQFV_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define VQFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/vqfv_pkg.sv
// Shared types and constants for the VLAN query frame validator.
// No dependencies; used by the channel interfaces and the top level.
package vqfv_pkg;

	localparam int MAX_FRAME_BYTES = 65535;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int OFF_W           = POS_W + 1;

	localparam int HEADER_BYTES    = 8;
	localparam int MAX_LEN_RESET   = 250;

	localparam logic [7:0] ATTR_OUI_LAST = 8'h0C;
	localparam logic [7:0] ATTR_TYPE_MIN = 8'd1;
	localparam logic [7:0] ATTR_TYPE_MAX = 8'd8;
	localparam logic [7:0] TYPE_NO_LIMIT = 8'd5;

	// attribute header byte index
	localparam logic [2:0] HDR_OUI_0     = 3'd0;
	localparam logic [2:0] HDR_OUI_1     = 3'd1;
	localparam logic [2:0] HDR_OUI_2     = 3'd2;
	localparam logic [2:0] HDR_TYPE      = 3'd3;
	localparam logic [2:0] HDR_LEN_HI    = 3'd4;
	localparam logic [2:0] HDR_LEN_LO    = 3'd5;
	localparam logic [2:0] HDR_DONE      = 3'd6;
	localparam logic [2:0] HDR_COMMITTED = 3'd7;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_BAD_TYPE = 3'd3,
		ST_BAD_LEN  = 3'd4
	} status_t;

endpackage

// File: rtl/core/vqfv_if.sv
// Valid/ready channel interfaces of the VLAN query frame validator.
// Depends on vqfv_pkg.
interface vqfv_in_if import vqfv_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface vqfv_out_if import vqfv_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic [OFF_W-1:0] end_offset;

	modport source (output valid, status, end_offset, input ready);
	modport sink   (input valid, status, end_offset, output ready);
endinterface

interface vqfv_cfg_if import vqfv_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] max_value_length;

	modport source (output valid, max_value_length, input ready);
	modport sink   (input valid, max_value_length, output ready);
endinterface

// File: rtl/core/vlan_query_frame_validator.sv
// VLAN query frame validator: one frame byte a beat in, one verdict beat per frame out.
// A user should know: one byte is taken every clock cycle; a byte is checked by the walk
// logic while it sits in the input register, the frame state takes the outcome as that
// byte leaves the register, and the verdict of a frame enters the result register as its last
// byte leaves it. The result register is the only point of backpressure: only a last byte
// waits on it, so a stalled result side holds up the stream only once it has a second
// verdict to deliver. The 8-byte frame header is skipped, then each attribute header
// (00 00 0C, type 1..8, 16-bit length) is checked and its data bytes skipped. status is
// ok, short frame, truncated attribute, bad type or bad length; the first fault wins.
// end_offset is where the walk ended (may pass the frame end) and is 0 unless ok. Bytes
// beyond MAX_FRAME_BYTES are ignored except for their last mark. max_value_length resets to 250;
// the user writes it through cfg only while no frame is in flight, which the block does not enforce.
// Depends on vqfv_pkg, vqfv_if.sv and vlan_query_frame_validator_assert.svh.
`include "vlan_query_frame_validator_assert.svh"

module vlan_query_frame_validator import vqfv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vqfv_in_if.sink    frame,
	vqfv_out_if.source result,
	vqfv_cfg_if.sink   cfg
);

	// ---------------------------------------------------------------- config register
	logic [7:0] max_len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'(MAX_LEN_RESET);
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_value_length;
		end
	end

	// ---------------------------------------------------------------- input register
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid_q;

	// only a last byte needs the result register
	assign advance     = byte_valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign frame.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// ---------------------------------------------------------------- frame state
	logic [POS_W-1:0] byte_pos_q;     // offset of the next byte, saturates at the cap
	logic [OFF_W-1:0] next_attr_q;    // where the next attribute begins
	logic [2:0]       hdr_idx_q;      // attribute header bytes seen
	logic [7:0]       attr_type_q;
	logic [7:0]       len_hi_q;
	status_t          cur_err_q;      // first fault of this attribute
	status_t          com_err_q;      // first fault of the walk

	logic [POS_W-1:0] byte_pos_d;
	logic [OFF_W-1:0] next_attr_d;
	logic [2:0]       hdr_idx_d;
	logic [7:0]       attr_type_d;
	logic [7:0]       len_hi_d;
	status_t          cur_err_d;
	status_t          com_err_d;
	status_t          fault;
	logic             in_range;
	logic             walk;
	logic [POS_W-1:0] pos_eff;
	status_t          status_d;
	logic [OFF_W-1:0] end_off_d;

	always_comb begin
		byte_pos_d  = byte_pos_q;
		next_attr_d = next_attr_q;
		hdr_idx_d   = hdr_idx_q;
		attr_type_d = attr_type_q;
		len_hi_d    = len_hi_q;
		cur_err_d   = cur_err_q;
		com_err_d   = com_err_q;
		fault       = ST_OK;

		in_range = byte_pos_q < POS_W'(MAX_FRAME_BYTES);
		walk     = in_range && (byte_pos_q >= POS_W'(HEADER_BYTES)) && (com_err_q == ST_OK);

		if (in_range) begin
			byte_pos_d = byte_pos_q + POS_W'(1);
		end

		if (walk) begin
			// seventh byte of an attribute: its verdict becomes final
			if (hdr_idx_q == HDR_DONE) begin
				if (cur_err_q != ST_OK) begin
					com_err_d = cur_err_q;
				end
				hdr_idx_d = HDR_COMMITTED;
			end
			// start of a new attribute
			if (com_err_d == ST_OK && OFF_W'(byte_pos_q) == next_attr_q) begin
				hdr_idx_d = HDR_OUI_0;
				cur_err_d = ST_OK;
			end
			if (com_err_d == ST_OK && hdr_idx_d < HDR_DONE) begin
				case (hdr_idx_d)
					HDR_OUI_0, HDR_OUI_1: begin
						if (byte_s1 != 8'd0) fault = ST_BAD_TYPE;
					end
					HDR_OUI_2: begin
						if (byte_s1 != ATTR_OUI_LAST) fault = ST_BAD_TYPE;
					end
					HDR_TYPE: begin
						attr_type_d = byte_s1;
						if (!(byte_s1 inside {[ATTR_TYPE_MIN:ATTR_TYPE_MAX]})) fault = ST_BAD_TYPE;
					end
					HDR_LEN_HI: begin
						len_hi_d = byte_s1;
					end
					HDR_LEN_LO: begin
						if (attr_type_q != TYPE_NO_LIMIT &&
						    (len_hi_q != 8'd0 || byte_s1 > max_len_q)) begin
							fault = ST_BAD_LEN;
						end
						next_attr_d = OFF_W'(byte_pos_q) + OFF_W'(1) + OFF_W'({len_hi_q, byte_s1});
					end
					default: begin
					end
				endcase
				if (cur_err_d == ST_OK) begin
					cur_err_d = fault;
				end
				hdr_idx_d = hdr_idx_d + 3'd1;
			end
		end

		// verdict, used on a last byte only
		pos_eff   = in_range ? byte_pos_q : POS_W'(MAX_FRAME_BYTES - 1);
		end_off_d = '0;
		if (pos_eff < POS_W'(HEADER_BYTES - 1)) begin
			status_d = ST_SHORT;
		end else if (com_err_d != ST_OK) begin
			status_d = com_err_d;
		end else if (pos_eff == POS_W'(HEADER_BYTES - 1)) begin
			status_d  = ST_OK;
			end_off_d = OFF_W'(HEADER_BYTES);
		end else if (hdr_idx_d <= HDR_DONE) begin
			status_d = ST_TRUNC;
		end else begin
			status_d  = ST_OK;
			end_off_d = next_attr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			next_attr_q <= OFF_W'(HEADER_BYTES);
			hdr_idx_q   <= HDR_OUI_0;
			attr_type_q <= '0;
			len_hi_q    <= '0;
			cur_err_q   <= ST_OK;
			com_err_q   <= ST_OK;
		end else if (advance) begin
			if (last_s1) begin
				// frame done: back to the start-of-frame state
				byte_pos_q  <= '0;
				next_attr_q <= OFF_W'(HEADER_BYTES);
				hdr_idx_q   <= HDR_OUI_0;
				attr_type_q <= '0;
				len_hi_q    <= '0;
				cur_err_q   <= ST_OK;
				com_err_q   <= ST_OK;
			end else begin
				byte_pos_q  <= byte_pos_d;
				next_attr_q <= next_attr_d;
				hdr_idx_q   <= hdr_idx_d;
				attr_type_q <= attr_type_d;
				len_hi_q    <= len_hi_d;
				cur_err_q   <= cur_err_d;
				com_err_q   <= com_err_d;
			end
		end
	end

	// ---------------------------------------------------------------- result register
	status_t          status_q;
	logic [OFF_W-1:0] end_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q  <= status_d;
			end_off_q <= end_off_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = status_q;
	assign result.end_offset = end_off_q;

	// ---------------------------------------------------------------- checks
	`VQFV_ASSERT_ALWAYS(a_fail_no_offset, clk, arst_n,
		!out_valid_q || status_q == ST_OK || end_off_q == '0,
		"end_offset nonzero on a failed frame")
	`VQFV_ASSERT_ALWAYS(a_ok_past_header, clk, arst_n,
		!out_valid_q || status_q != ST_OK || end_off_q >= OFF_W'(HEADER_BYTES),
		"ok verdict with offset inside the header")
	`VQFV_ASSERT_ALWAYS(a_commit_final, clk, arst_n,
		com_err_q == ST_OK || hdr_idx_q == HDR_COMMITTED,
		"walk fault recorded before the attribute was committed")
	`VQFV_ASSERT_NEXT(a_frame_restart, clk, arst_n,
		advance && last_s1,
		byte_pos_q == '0 && hdr_idx_q == HDR_OUI_0 && com_err_q == ST_OK,
		"frame state not cleared after a last byte")

endmodule

// File: tb/vlan_query_frame_validator_test.sv
// Self-checking bench for vlan_query_frame_validator: byte stream in, one verdict per frame out.
// Depends on vqfv_pkg, vqfv_if.sv and the validator RTL; a built-in walk predictor, or the hand
// verdict of a directed row, sets the expected verdicts; a short table of directed frames runs ahead of random ones.
`timescale 1ns / 1ps

module vlan_query_frame_validator_test;
	import vqfv_pkg::*;

	// run limits
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 300;  // long result-side hold-off
	localparam int unsigned PHASE_BYTES  = 30;   // least random bytes per register setting
	localparam int unsigned MAX_ERR_LINES = 20;
	localparam int          N_ROWS       = 17;

	typedef struct packed {
		status_t          st;
		logic [OFF_W-1:0] off;
	} verdict_t;

	// directed frame: length, first 24 bytes (byte 0 leftmost, rest of frame zero),
	// and a hand-written verdict where it is obvious
	typedef struct packed {
		logic [16:0]      len;
		logic [191:0]     head;
		bit               typed;
		status_t          st;
		logic [OFF_W-1:0] off;
	} frame_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vqfv_in_if  frame_ch ();
	vqfv_out_if result_ch ();
	vqfv_cfg_if cfg_ch ();

	vlan_query_frame_validator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Walk predictor: mirrors the attribute walk on every accepted byte
	// ------------------------------------------------------------------
	logic [7:0]  max_len;
	int unsigned pos_cnt;      // offset of the next byte in the frame
	int unsigned next_start;   // where the next attribute begins (17-bit value)
	logic [2:0]  hdr_idx;      // attribute header bytes seen so far
	logic [7:0]  attr_type;
	logic [7:0]  len_hi;
	status_t     attr_err;     // first fault of the attribute being walked
	status_t     walk_err;     // first committed fault of the frame

	verdict_t    verdict_q [$];  // verdicts still owed by the block
	logic [7:0]  fb [$];         // frame being sent

	bit          use_typed;
	verdict_t    typed_v;
	bit          tx_quiet;
	bit          rx_quiet;
	bit          hold_rx;
	bit          squeeze_go;

	int unsigned err_cnt;
	int unsigned cycle_cnt;
	int unsigned bytes_sent;
	int unsigned frames_sent;
	int unsigned verdicts_seen;
	int unsigned st_seen [8];

	task automatic clear_walk();
		pos_cnt    = 0;
		next_start = HEADER_BYTES;
		hdr_idx    = HDR_OUI_0;
		attr_type  = 8'h00;
		len_hi     = 8'h00;
		attr_err   = ST_OK;
		walk_err   = ST_OK;
	endtask

	task automatic note_fault(input status_t code);
		if (attr_err == ST_OK)
			attr_err = code;
	endtask

	task automatic walk_byte(input logic [7:0] b, input bit last,
			output bit fire, output verdict_t v);
		int unsigned p;
		int unsigned pe;
		p    = pos_cnt;
		pe   = p;
		fire = 1'b0;
		v.st  = ST_OK;
		v.off = '0;
		if (p < MAX_FRAME_BYTES) begin
			if (p >= HEADER_BYTES && walk_err == ST_OK) begin
				// a byte past a complete attribute header commits its verdict
				if (hdr_idx == HDR_DONE) begin
					if (attr_err != ST_OK)
						walk_err = attr_err;
					hdr_idx = HDR_COMMITTED;
				end
				if (walk_err == ST_OK && p == next_start) begin
					hdr_idx  = HDR_OUI_0;
					attr_err = ST_OK;
				end
				if (walk_err == ST_OK && hdr_idx < HDR_DONE) begin
					case (hdr_idx)
						HDR_OUI_0, HDR_OUI_1: begin
							if (b != 8'h00)
								note_fault(ST_BAD_TYPE);
						end
						HDR_OUI_2: begin
							if (b != ATTR_OUI_LAST)
								note_fault(ST_BAD_TYPE);
						end
						HDR_TYPE: begin
							attr_type = b;
							if (b < ATTR_TYPE_MIN || b > ATTR_TYPE_MAX)
								note_fault(ST_BAD_TYPE);
						end
						HDR_LEN_HI: begin
							len_hi = b;
						end
						default: begin
							// type five has no length limit
							if (attr_type != TYPE_NO_LIMIT && (len_hi != 8'h00 || b > max_len))
								note_fault(ST_BAD_LEN);
							next_start = (p + 1 + {len_hi, b}) & 32'h1FFFF;
						end
					endcase
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			pos_cnt = p + 1;
		end else begin
			// overlong frame: judged as if it ended at the size limit
			pe = MAX_FRAME_BYTES - 1;
		end
		if (last) begin
			fire = 1'b1;
			if (pe < HEADER_BYTES - 1)
				v.st = ST_SHORT;
			else if (walk_err != ST_OK)
				v.st = walk_err;
			else if (pe == HEADER_BYTES - 1)
				v.off = OFF_W'(HEADER_BYTES);
			else if (hdr_idx <= HDR_DONE)
				v.st = ST_TRUNC;
			else
				v.off = OFF_W'(next_start);
			clear_walk();
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_ERR_LINES)
			$display("ERROR verdict %0d: %s", verdicts_seen, msg);
	endtask

	// Result side: random stall per verdict, plus the long hold-off while hold_rx is up.
	initial begin : verdict_sink
		int unsigned stall;
		verdict_t    want;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			while (hold_rx) begin
				result_ch.ready <= 1'b0;
				@(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			verdicts_seen++;
			st_seen[int'(result_ch.status)]++;
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, status %0d end_offset %0d",
					result_ch.status, result_ch.end_offset));
			end else begin
				want = verdict_q.pop_front();
				if (result_ch.status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d",
						result_ch.status, want.st));
				if (result_ch.end_offset !== want.off)
					report_mismatch($sformatf("end_offset %0d, expected %0d",
						result_ch.end_offset, want.off));
			end
		end
	end

	// Long hold-off: counted here, started once by the stimulus.
	initial begin : result_hold
		hold_rx = 1'b0;
		wait (squeeze_go === 1'b1);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Watchdog.
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
			verdict_q.size());
		$display("vlan_query_frame_validator: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// One byte beat; called just after a rising edge, returns just after its acceptance.
	task automatic put_byte(input logic [7:0] b, input bit last);
		int unsigned gap;
		bit          fire;
		verdict_t    v;
		gap = tx_quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid     <= 1'b1;
		frame_ch.data_byte <= b;
		frame_ch.last_byte <= last;
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
		walk_byte(b, last, fire, v);
		bytes_sent++;
		if (fire) begin
			verdict_q.push_back(use_typed ? typed_v : v);
			frames_sent++;
		end
	endtask

	task automatic send_frame();
		foreach (fb[i])
			put_byte(fb[i], i == fb.size() - 1);
	endtask

	// Drop valid, wait for every owed verdict, then let the block drain.
	task automatic settle();
		frame_ch.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [7:0] val);
		cfg_ch.valid            <= 1'b1;
		cfg_ch.max_value_length <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		max_len = val;
	endtask

	// Mostly well-formed frames with random content; some short, cut or with a bad field.
	task automatic build_random_frame();
		int unsigned flavor;
		int unsigned n_attr;
		int unsigned twist;
		int unsigned room;
		logic [7:0]  oui0, oui1, oui2, ty, lh, ll;
		bit          stop;
		fb.delete();
		stop   = 1'b0;
		flavor = $urandom_range(0, 9);
		if (flavor == 0) begin
			repeat ($urandom_range(1, HEADER_BYTES)) fb.push_back(8'($urandom));
			return;
		end
		repeat (HEADER_BYTES) fb.push_back(8'($urandom));
		n_attr = $urandom_range(0, 3);
		for (int a = 0; a < int'(n_attr) && !stop; a++) begin
			oui0 = 8'h00;
			oui1 = 8'h00;
			oui2 = ATTR_OUI_LAST;
			ty   = 8'($urandom_range(ATTR_TYPE_MIN, ATTR_TYPE_MAX));
			lh   = 8'h00;
			room = (max_len < 8'd6) ? int'(max_len) : 6;
			ll   = 8'($urandom_range((room == 0) ? 0 : 1, room));
			twist = $urandom_range(0, 13);
			case (twist)
				0: oui0 = 8'($urandom);
				1: oui1 = 8'($urandom);
				2: oui2 = 8'($urandom);
				3: ty   = 8'($urandom);
				4: lh   = 8'($urandom_range(1, 255));
				5: begin
					if (max_len != 8'hFF)
						ll = 8'($urandom_range(int'(max_len) + 1, 255));
				end
				6: begin
					// unlimited type with a length that may run past the frame
					ty = TYPE_NO_LIMIT;
					lh = 8'($urandom);
					ll = 8'($urandom);
				end
				default: ;
			endcase
			fb.push_back(oui0);
			fb.push_back(oui1);
			fb.push_back(oui2);
			fb.push_back(ty);
			fb.push_back(lh);
			fb.push_back(ll);
			if (lh == 8'h00 && ll <= 8'd6) begin
				repeat (ll) fb.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom));
				stop = 1'b1;
			end
		end
		case (flavor)
			1: begin
				// cut anywhere past the frame header
				room = $urandom_range(HEADER_BYTES, fb.size());
				while (fb.size() > room) void'(fb.pop_back());
			end
			2: repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
			default: ;
		endcase
	endtask

	frame_row_t rows [N_ROWS] = '{
		// fewer than 8 bytes: short frame
		'{17'd1, 192'hFF000000_00000000_00000000_00000000_00000000_00000000,
			1'b1, ST_SHORT, 17'd0},
		'{17'd7, 192'h80402010_08040200_00000000_00000000_00000000_00000000,
			1'b1, ST_SHORT, 17'd0},
		// header only
		'{17'd8, 192'hFFFFFFFF_FFFFFFFF_00000000_00000000_00000000_00000000,
			1'b1, ST_OK, 17'd8},
		// one attribute byte, then an attribute header with a bad type but cut short
		'{17'd9, 192'h00000000_00000000_00000000_00000000_00000000_00000000,
			1'b1, ST_TRUNC, 17'd0},
		'{17'd14, 192'h55AA55AA_55AA55AA_00000C09_00010000_00000000_00000000,
			1'b1, ST_TRUNC, 17'd0},
		// smallest complete attribute
		'{17'd15, 192'h01020304_05060708_00000C01_0001AA00_00000000_00000000,
			1'b0, ST_OK, 17'd0},
		// bad prefix bytes, type 0 and type 9
		'{17'd15, 192'h00000000_00000000_01000C01_0001AA00_00000000_00000000,
			1'b1, ST_BAD_TYPE, 17'd0},
		'{17'd15, 192'h00000000_00000000_00000D01_0001AA00_00000000_00000000,
			1'b1, ST_BAD_TYPE, 17'd0},
		'{17'd15, 192'h00000000_00000000_00000C00_0001AA00_00000000_00000000,
			1'b1, ST_BAD_TYPE, 17'd0},
		'{17'd15, 192'h00000000_00000000_00000C09_0001AA00_00000000_00000000,
			1'b1, ST_BAD_TYPE, 17'd0},
		// length high byte set, then low byte one over the reset limit
		'{17'd15, 192'h00000000_00000000_00000C08_0100AA00_00000000_00000000,
			1'b1, ST_BAD_LEN, 17'd0},
		'{17'd15, 192'h00000000_00000000_00000C01_00FBAA00_00000000_00000000,
			1'b1, ST_BAD_LEN, 17'd0},
		// length at the limit: walk ends past the frame
		'{17'd15, 192'h00000000_00000000_00000C01_00FAAA00_00000000_00000000,
			1'b0, ST_OK, 17'd0},
		// type five ignores the limit, largest length
		'{17'd15, 192'h00000000_00000000_00000C05_FFFFAA00_00000000_00000000,
			1'b0, ST_OK, 17'd0},
		// bad type then bad length: the first fault wins
		'{17'd22, 192'h00000000_00000000_00000C09_0001AA00_000C0101_00BB0000,
			1'b1, ST_BAD_TYPE, 17'd0},
		// two good attributes
		'{17'd23, 192'h00000000_00000000_00000C02_0001AA00_000C0800_02BBCC00,
			1'b0, ST_OK, 17'd0},
		// zero length: the next attribute starts on the seventh byte
		'{17'd15, 192'h00000000_00000000_00000C03_0000FF00_00000000_00000000,
			1'b0, ST_OK, 17'd0}
	};

	initial begin : stimulus
		logic [7:0]  cfg_vals [4];
		int unsigned mark;
		frame_ch.valid          = 1'b0;
		frame_ch.data_byte      = 8'h00;
		frame_ch.last_byte      = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.max_value_length = 8'h00;
		max_len = 8'(MAX_LEN_RESET);
		clear_walk();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset limit
		for (int r = 0; r < N_ROWS; r++) begin
			fb.delete();
			for (int i = 0; i < int'(rows[r].len); i++) begin
				if (i < 24)
					fb.push_back(rows[r].head[191 - 8*i -: 8]);
				else
					fb.push_back(8'h00);
			end
			use_typed = rows[r].typed;
			typed_v.st  = rows[r].st;
			typed_v.off = rows[r].off;
			tx_quiet  = 1'b0;
			send_frame();
		end
		use_typed = 1'b0;

		// random frames under several limits, extremes included
		cfg_vals[0] = 8'h00;
		cfg_vals[1] = 8'hFF;
		cfg_vals[2] = 8'($urandom_range(1, 254));
		cfg_vals[3] = 8'(MAX_LEN_RESET);
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_max_len(cfg_vals[ph]);
			if (ph == 0) begin
				// hold the result side and push tiny frames so that the input stalls
				squeeze_go <= 1'b1;
				tx_quiet = 1'b1;
				repeat (24) begin
					fb.delete();
					repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
					send_frame();
				end
			end
			mark = bytes_sent;
			while (bytes_sent < mark + PHASE_BYTES) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				build_random_frame();
				send_frame();
			end
		end
		tx_quiet = 1'b0;
		settle();

		$display("Sent %0d frames in %0d bytes; limits 250, 0, 255, %0d and 250 again.",
			frames_sent, bytes_sent, cfg_vals[2]);
		$display("Verdicts: %0d ok, %0d short, %0d truncated, %0d bad type, %0d bad length.",
			st_seen[ST_OK], st_seen[ST_SHORT], st_seen[ST_TRUNC], st_seen[ST_BAD_TYPE],
			st_seen[ST_BAD_LEN]);
		if (err_cnt == 0) begin
			$display("vlan_query_frame_validator: match");
		end else begin
			$display("vlan_query_frame_validator: mismatch");
		end
		$finish;
	end

endmodule
